// ===== hw/rtl/joystick_differential_drive_mixer_defines.svh =====
// Assertion macros used by the checker in jddm_checker.sv.
`ifndef JOYSTICK_DIFFERENTIAL_DRIVE_MIXER_DEFINES_SVH
`define JOYSTICK_DIFFERENTIAL_DRIVE_MIXER_DEFINES_SVH

// Condition that must hold at every clock edge out of reset.
`define JDDM_ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("jddm: invariant violated");

// Antecedent in this cycle implies consequent in the next one.
`define JDDM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("jddm: next-cycle check failed");

`endif

// ===== hw/rtl/jddm_pkg.sv =====
package jddm_pkg;

    localparam int AXIS_W  = 10;
    localparam int DUTY_W  = 8;
    localparam int ANGLE_W = 8;
    localparam int STEP_W  = 4;
    localparam int PAT_W   = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;

    localparam logic [AXIS_W-1:0]  DEAD_LOW  = 10'd470;
    localparam logic [AXIS_W-1:0]  DEAD_HIGH = 10'd550;
    localparam logic [DUTY_W-1:0]  DUTY_MAX  = 8'd255;
    localparam logic [ANGLE_W-1:0] ANGLE_MAX = 8'd180;

    // Reset values of the configuration registers
    localparam logic [DUTY_W-1:0] MIN_DUTY_RST   = 8'd70;
    localparam logic [STEP_W-1:0] SERVO_STEP_RST = 4'd3;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MIN_DUTY   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SERVO_STEP = 1'd1;

    // Bridge patterns
    localparam logic [PAT_W-1:0] PAT_OFF  = 2'd0;
    localparam logic [PAT_W-1:0] PAT_LOW  = 2'd1;
    localparam logic [PAT_W-1:0] PAT_HIGH = 2'd2;

    // Reciprocals for floor(p/470) and floor(p/473), p < 2^17, shift 28
    localparam int RECIP_SHIFT = 28;
    localparam logic [19:0] RECIP_LOW  = 20'd571140;
    localparam logic [19:0] RECIP_HIGH = 20'd567517;

    typedef struct packed {
        logic              pattern_load;
        logic [PAT_W-1:0]  pattern;
        logic [DUTY_W-1:0] right_duty;
        logic [DUTY_W-1:0] left_duty;
    } drive_t;

    // floor(span*255/470) or floor(span*255/473), span <= 473
    function automatic logic [DUTY_W-1:0] scale_dist(input logic [8:0] span,
                                                     input logic       high_side);
        logic [16:0] p;
        logic [36:0] prod;
        p    = {span, 8'd0} - {8'd0, span};
        prod = {20'd0, p} * {17'd0, (high_side ? RECIP_HIGH : RECIP_LOW)};
        return prod[RECIP_SHIFT+DUTY_W-1:RECIP_SHIFT];
    endfunction

    function automatic logic [ANGLE_W-1:0] angle_up(input logic [ANGLE_W-1:0] a,
                                                    input logic [STEP_W-1:0]  step);
        logic [ANGLE_W:0] r;
        r = {1'b0, a} + {5'd0, step};
        return (r > {1'b0, ANGLE_MAX}) ? ANGLE_MAX : r[ANGLE_W-1:0];
    endfunction

    function automatic logic [ANGLE_W-1:0] angle_down(input logic [ANGLE_W-1:0] a,
                                                      input logic [STEP_W-1:0]  step);
        return (a > {4'd0, step}) ? (a - {4'd0, step}) : '0;
    endfunction

endpackage

// ===== hw/rtl/jddm_in_if.sv =====
interface jddm_in_if
    import jddm_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [AXIS_W-1:0] joystick_x;
    logic [AXIS_W-1:0] joystick_y;
    logic              arm_raise_pressed;
    logic              arm_lower_pressed;
    logic              grip_raise_pressed;
    logic              grip_lower_pressed;

    modport source (
        output valid, joystick_x, joystick_y, arm_raise_pressed, arm_lower_pressed,
               grip_raise_pressed, grip_lower_pressed,
        input  ready
    );
    modport sink (
        input  valid, joystick_x, joystick_y, arm_raise_pressed, arm_lower_pressed,
               grip_raise_pressed, grip_lower_pressed,
        output ready
    );
endinterface

// ===== hw/rtl/jddm_out_if.sv =====
interface jddm_out_if
    import jddm_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [PAT_W-1:0]   bridge_pattern;
    logic [DUTY_W-1:0]  right_duty;
    logic [DUTY_W-1:0]  left_duty;
    logic [ANGLE_W-1:0] arm_angle;
    logic [ANGLE_W-1:0] grip_angle;

    modport source (
        output valid, bridge_pattern, right_duty, left_duty, arm_angle, grip_angle,
        input  ready
    );
    modport sink (
        input  valid, bridge_pattern, right_duty, left_duty, arm_angle, grip_angle,
        output ready
    );
endinterface

// ===== hw/rtl/joystick_differential_drive_mixer.sv =====
// Channel  | Dir | Payload
// ---------+-----+----------------------------------------------------------
// pkt      | in  | joystick_x, joystick_y, four button flags
// res      | out | bridge_pattern, right_duty, left_duty, arm_angle, grip_angle
// cfg_*    | in  | write-only: index 0 min_duty, index 1 servo_step
//
// One item per cycle sustained while res.ready is held; an accepted item is
// captured in stage 1 and then in the result register, which drives res.valid.
// Stage 1 is the input register, the mix and servo logic sit between it and
// the result register; the throttle and steer scalers are one constant
// reciprocal multiply each. Reset clears held pattern and both angles to 0
// and loads min_duty 70, servo_step 3. A stalled result holds stage 1,
// which in turn drops pkt.ready only when it is occupied.
module joystick_differential_drive_mixer
    import jddm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    jddm_in_if.sink               pkt,
    jddm_out_if.source            res,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);
    // configuration
    logic [DUTY_W-1:0] min_duty_reg;
    logic [STEP_W-1:0] servo_step_reg;

    // stage 1: captured packet
    logic              s1_valid_reg;
    logic [AXIS_W-1:0] s1_x_reg, s1_y_reg;
    logic [3:0]        s1_btn_reg;   // arm raise, arm lower, grip raise, grip lower

    // persistent state
    logic [PAT_W-1:0]   held_pattern_reg, held_pattern_next;
    logic [ANGLE_W-1:0] arm_reg, arm_next;
    logic [ANGLE_W-1:0] grip_reg, grip_next;

    // result register
    logic               out_valid_reg;
    logic [PAT_W-1:0]   out_pattern_reg;
    logic [DUTY_W-1:0]  out_right_reg, out_left_reg;
    logic [ANGLE_W-1:0] out_arm_reg, out_grip_reg;

    logic   advance;   // stage 1 moves into the result register
    logic   s1_load;
    drive_t drive;

    assign advance   = s1_valid_reg && (!out_valid_reg || res.ready);
    assign pkt.ready = !s1_valid_reg || advance;
    assign s1_load   = pkt.valid && pkt.ready;

    jddm_mix u_mix (
        .joystick_x (s1_x_reg),
        .joystick_y (s1_y_reg),
        .min_duty   (min_duty_reg),
        .drive      (drive)
    );

    // Servo step: only the highest-priority pressed button acts.
    always_comb
    begin
        held_pattern_next = drive.pattern_load ? drive.pattern : held_pattern_reg;
        arm_next  = arm_reg;
        grip_next = grip_reg;
        if (s1_btn_reg[3])
            arm_next = angle_up(arm_reg, servo_step_reg);
        else if (s1_btn_reg[2])
            arm_next = angle_down(arm_reg, servo_step_reg);
        else if (s1_btn_reg[1])
            grip_next = angle_up(grip_reg, servo_step_reg);
        else if (s1_btn_reg[0])
            grip_next = angle_down(grip_reg, servo_step_reg);
    end

    // control and state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_duty_reg     <= MIN_DUTY_RST;
            servo_step_reg   <= SERVO_STEP_RST;
            s1_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            held_pattern_reg <= PAT_OFF;
            arm_reg          <= '0;
            grip_reg         <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_MIN_DUTY:   min_duty_reg   <= cfg_data;
                    REG_SERVO_STEP: servo_step_reg <= cfg_data[STEP_W-1:0];
                    default: ;
                endcase
            end

            if (s1_load)
                s1_valid_reg <= 1'b1;
            else if (advance)
                s1_valid_reg <= 1'b0;

            if (advance)
            begin
                out_valid_reg    <= 1'b1;
                held_pattern_reg <= held_pattern_next;
                arm_reg          <= arm_next;
                grip_reg         <= grip_next;
            end
            else if (res.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_x_reg   <= pkt.joystick_x;
            s1_y_reg   <= pkt.joystick_y;
            s1_btn_reg <= {pkt.arm_raise_pressed, pkt.arm_lower_pressed,
                           pkt.grip_raise_pressed, pkt.grip_lower_pressed};
        end
        if (advance)
        begin
            out_pattern_reg <= held_pattern_next;
            out_right_reg   <= drive.right_duty;
            out_left_reg    <= drive.left_duty;
            out_arm_reg     <= arm_next;
            out_grip_reg    <= grip_next;
        end
    end

    assign res.valid          = out_valid_reg;
    assign res.bridge_pattern = out_pattern_reg;
    assign res.right_duty     = out_right_reg;
    assign res.left_duty      = out_left_reg;
    assign res.arm_angle      = out_arm_reg;
    assign res.grip_angle     = out_grip_reg;
endmodule

// ===== hw/rtl/jddm_mix.sv =====
// Throttle/steer mixing: deadband, scaling, clamps, buzz floor, bridge pattern.
module jddm_mix
    import jddm_pkg::*;
(
    input  logic [AXIS_W-1:0] joystick_x,
    input  logic [AXIS_W-1:0] joystick_y,
    input  logic [DUTY_W-1:0] min_duty,
    output drive_t            drive
);
    logic              y_low, y_high, x_low, x_high;
    logic [AXIS_W-1:0] y_dist_full, x_dist_full;
    logic [DUTY_W-1:0] base, steer;
    logic [DUTY_W:0]   right_w, left_w;
    logic [DUTY_W-1:0] right_c, left_c;

    always_comb
    begin
        y_low  = joystick_y < DEAD_LOW;
        y_high = joystick_y > DEAD_HIGH;
        x_low  = joystick_x < DEAD_LOW;
        x_high = joystick_x > DEAD_HIGH;

        y_dist_full = y_low ? (DEAD_LOW - joystick_y) : (joystick_y - DEAD_HIGH);
        x_dist_full = x_low ? (DEAD_LOW - joystick_x) : (joystick_x - DEAD_HIGH);

        base  = (y_low || y_high) ? scale_dist(y_dist_full[8:0], y_high) : '0;
        steer = scale_dist(x_dist_full[8:0], x_high);

        right_w = {1'b0, base};
        left_w  = {1'b0, base};
        if (x_low)
        begin
            right_w = (base > steer) ? {1'b0, base - steer} : '0;
            left_w  = {1'b0, base} + {1'b0, steer};
        end
        else if (x_high)
        begin
            right_w = {1'b0, base} + {1'b0, steer};
            left_w  = (base > steer) ? {1'b0, base - steer} : '0;
        end
        right_c = right_w[DUTY_W] ? DUTY_MAX : right_w[DUTY_W-1:0];
        left_c  = left_w[DUTY_W]  ? DUTY_MAX : left_w[DUTY_W-1:0];

        drive.pattern_load = y_low || y_high;
        drive.pattern      = y_low ? PAT_LOW : PAT_HIGH;
        drive.right_duty   = (right_c < min_duty) ? '0 : right_c;
        drive.left_duty    = (left_c < min_duty) ? '0 : left_c;
    end
endmodule

// ===== hw/rtl/jddm_checker.sv =====
`include "joystick_differential_drive_mixer_defines.svh"

module jddm_checker
    import jddm_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               res_valid,
    input logic               res_ready,
    input logic [PAT_W-1:0]   bridge_pattern,
    input logic [DUTY_W-1:0]  right_duty,
    input logic [DUTY_W-1:0]  left_duty,
    input logic [ANGLE_W-1:0] arm_angle,
    input logic [ANGLE_W-1:0] grip_angle
);
    `JDDM_ASSERT_NEXT(a_res_hold, clk, rst_n, res_valid && !res_ready, res_valid)
    `JDDM_ASSERT_NEXT(a_res_stable, clk, rst_n, res_valid && !res_ready, $stable(bridge_pattern) && $stable(right_duty) && $stable(left_duty) && $stable(arm_angle) && $stable(grip_angle))
    `JDDM_ASSERT_ALWAYS(a_pattern_code, clk, rst_n, !res_valid || bridge_pattern <= PAT_HIGH)
    `JDDM_ASSERT_ALWAYS(a_angle_range, clk, rst_n, !res_valid || (arm_angle <= ANGLE_MAX && grip_angle <= ANGLE_MAX))
endmodule

bind joystick_differential_drive_mixer jddm_checker u_jddm_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .res_valid      (res.valid),
    .res_ready      (res.ready),
    .bridge_pattern (res.bridge_pattern),
    .right_duty     (res.right_duty),
    .left_duty      (res.left_duty),
    .arm_angle      (res.arm_angle),
    .grip_angle     (res.grip_angle)
);
